/* hdl/parallel_port_cart_ram_register_port_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the parallel port cart RAM register port
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_PORT_CART_RAM_REGISTER_PORT_MACROS_SVH
`define PARALLEL_PORT_CART_RAM_REGISTER_PORT_MACROS_SVH

// same-cycle implication
`define PPRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define PPRP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/pprp_pkg.sv */
// ----------------------------------------------------------------------------
// pprp_pkg
// Types and constants of the parallel port cart RAM register port.
// ----------------------------------------------------------------------------
`default_nettype none

package pprp_pkg;

    localparam int unsigned OUT_ADDR_W = 29;

    localparam logic [7:0] KEY_HIGH_VALUE = 8'h0a;
    localparam logic [7:0] KEY_LOW_VALUE  = 8'h05;
    localparam logic [4:0] TOP_FIELD_MASK = 5'h1f;

    typedef enum logic [1:0] {
        OP_ADDR_WRITE   = 2'd0,
        OP_DATA_WRITE   = 2'd1,
        OP_DATA_READ    = 2'd2,
        OP_TARGET_WRITE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        IDX_ADDR0    = 3'd0,
        IDX_ADDR1    = 3'd1,
        IDX_ADDR2    = 3'd2,
        IDX_ADDR3    = 3'd3,
        IDX_RAM_DATA = 3'd4,
        IDX_MODE     = 3'd5,
        IDX_KEY_HIGH = 3'd6,
        IDX_KEY_LOW  = 3'd7
    } t_index;

    typedef struct packed {
        t_op        op;
        logic [7:0] port_byte;
        logic [7:0] ram_return_byte;
        logic       target_window;
        logic       target_power;
    } t_in_item;

    typedef struct packed {
        logic [7:0]            read_byte;
        logic                  ram_write;
        logic                  ram_read;
        logic [OUT_ADDR_W-1:0] ram_address;
        logic [7:0]            ram_write_byte;
        logic                  port_unlocked;
        logic                  cart_at_low_window;
        logic                  target_ram_writable;
    } t_out_item;

endpackage

`default_nettype wire

/* hdl/pprp_core.sv */
// ----------------------------------------------------------------------------
// pprp_core
// Register file, address pointer, keys and status flags. Computes the result
// of one port transfer from the current state and updates the state on fire.
// ----------------------------------------------------------------------------
`default_nettype none

module pprp_core
    import pprp_pkg::*;
#(
    parameter int unsigned ADDRESS_BITS    = 29,
    parameter int unsigned PAGE_COUNT_BITS = 9
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_item  i_item,
    output t_out_item      o_result
);

    localparam logic [ADDRESS_BITS-1:0] PAGE_MASK =
        ADDRESS_BITS'((64'd1 << PAGE_COUNT_BITS) - 64'd1);

    t_index                  r_sel,          n_sel;
    logic [ADDRESS_BITS-1:0] r_ptr,          n_ptr;
    logic [7:0]              r_key_low,      n_key_low;
    logic [7:0]              r_key_high,     n_key_high;
    logic [1:0]              r_mode,         n_mode;
    logic                    r_ram_wr_flag,  n_ram_wr_flag;
    logic                    r_upper_flag,   n_upper_flag;
    logic                    r_switched_off, n_switched_off;

    logic                    v_unlocked;
    logic [31:0]             v_ptr32;
    logic [31:0]             v_set32;
    logic [ADDRESS_BITS-1:0] v_ptr_adv;

    always_comb begin
        v_unlocked = (r_key_high == KEY_HIGH_VALUE) && (r_key_low == KEY_LOW_VALUE);
        v_ptr32    = 32'(r_ptr);
        v_ptr_adv  = (r_ptr & ~PAGE_MASK) | ((r_ptr + ADDRESS_BITS'(1)) & PAGE_MASK);
        v_set32    = v_ptr32;

        n_sel          = r_sel;
        n_ptr          = r_ptr;
        n_key_low      = r_key_low;
        n_key_high     = r_key_high;
        n_mode         = r_mode;
        n_ram_wr_flag  = r_ram_wr_flag;
        n_upper_flag   = r_upper_flag;
        n_switched_off = r_switched_off;

        o_result = '0;

        case (i_item.op)
            OP_ADDR_WRITE: begin
                n_sel = t_index'(i_item.port_byte[2:0]);
            end
            OP_DATA_WRITE: begin
                if (r_sel == IDX_KEY_HIGH) begin
                    n_key_high = i_item.port_byte;
                end else if (r_sel == IDX_KEY_LOW) begin
                    n_key_low = i_item.port_byte;
                end else if (v_unlocked) begin
                    case (r_sel)
                        IDX_ADDR0: begin
                            v_set32[7:0] = i_item.port_byte;
                            n_ptr        = v_set32[ADDRESS_BITS-1:0];
                        end
                        IDX_ADDR1: begin
                            v_set32[15:8] = i_item.port_byte;
                            n_ptr         = v_set32[ADDRESS_BITS-1:0];
                        end
                        IDX_ADDR2: begin
                            v_set32[23:16] = i_item.port_byte;
                            n_ptr          = v_set32[ADDRESS_BITS-1:0];
                        end
                        IDX_ADDR3: begin
                            v_set32[31:24] = i_item.port_byte;
                            n_ptr          = v_set32[ADDRESS_BITS-1:0];
                        end
                        IDX_RAM_DATA: begin
                            o_result.ram_write      = 1'b1;
                            o_result.ram_address    = v_ptr32[OUT_ADDR_W-1:0];
                            o_result.ram_write_byte = i_item.port_byte;
                            n_ptr                   = v_ptr_adv;
                        end
                        IDX_MODE: begin
                            n_mode = i_item.port_byte[1:0];
                            if (!i_item.port_byte[0]) begin
                                n_ram_wr_flag = 1'b0;
                            end
                            if (!i_item.port_byte[1]) begin
                                n_upper_flag   = 1'b0;
                                n_switched_off = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_DATA_READ: begin
                if (v_unlocked) begin
                    case (r_sel)
                        IDX_ADDR0: o_result.read_byte = v_ptr32[7:0];
                        IDX_ADDR1: o_result.read_byte = v_ptr32[15:8];
                        IDX_ADDR2: o_result.read_byte = v_ptr32[23:16];
                        IDX_ADDR3: begin
                            o_result.read_byte = {i_item.target_power, r_ram_wr_flag,
                                                  r_upper_flag,
                                                  v_ptr32[28:24] & TOP_FIELD_MASK};
                        end
                        IDX_RAM_DATA: begin
                            o_result.ram_read    = 1'b1;
                            o_result.ram_address = v_ptr32[OUT_ADDR_W-1:0];
                            o_result.read_byte   = i_item.ram_return_byte;
                            n_ptr                = v_ptr_adv;
                        end
                        default: o_result.read_byte = '0;
                    endcase
                end
            end
            default: begin
                if (!i_item.target_window) begin
                    if (r_mode[0] && !r_switched_off) begin
                        n_ram_wr_flag = 1'b1;
                    end
                end else if (r_mode[1]) begin
                    n_upper_flag   = 1'b1;
                    n_switched_off = 1'b1;
                end else if (r_mode[0]) begin
                    n_ram_wr_flag = 1'b1;
                end
            end
        endcase

        o_result.port_unlocked       = (n_key_high == KEY_HIGH_VALUE) &&
                                       (n_key_low == KEY_LOW_VALUE);
        o_result.cart_at_low_window  = n_switched_off;
        o_result.target_ram_writable = n_mode[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel          <= IDX_ADDR0;
            r_ptr          <= '0;
            r_key_low      <= '0;
            r_key_high     <= '0;
            r_mode         <= '0;
            r_ram_wr_flag  <= 1'b0;
            r_upper_flag   <= 1'b0;
            r_switched_off <= 1'b0;
        end else if (i_fire) begin
            r_sel          <= n_sel;
            r_ptr          <= n_ptr;
            r_key_low      <= n_key_low;
            r_key_high     <= n_key_high;
            r_mode         <= n_mode;
            r_ram_wr_flag  <= n_ram_wr_flag;
            r_upper_flag   <= n_upper_flag;
            r_switched_off <= n_switched_off;
        end
    end

endmodule

`default_nettype wire

/* hdl/parallel_port_cart_ram_register_port.sv */
// ----------------------------------------------------------------------------
// parallel_port_cart_ram_register_port
// Card side of a strobed byte-wide parallel port in front of emulator RAM.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one port
// strobe or target write event per transfer. Output channel (o_out_valid /
// i_out_ready / o_out_data) returns exactly one result per input, in order.
// Each item passes an input register, one level of register-file logic,
// and a result register: o_out_valid rises when the item moves from the
// input register into the result register; throughput one item per
// cycle while the receiver does not stall. The state update of an item
// happens as it moves into the result register, so the next item sees it.
// When the receiver stalls, the result register holds, then the input
// register fills and o_in_ready drops; no item is lost.
// Synchronous reset clears both pipeline valids, the index, pointer, keys,
// mode and flags: the port starts locked with RAM read only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "parallel_port_cart_ram_register_port_macros.svh"

module parallel_port_cart_ram_register_port
    import pprp_pkg::*;
#(
    parameter int unsigned ADDRESS_BITS    = 29,
    parameter int unsigned PAGE_COUNT_BITS = 9
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      v_move;
    t_out_item v_result;
    logic      v_rw_clash;
    logic      v_quiet;

    assign v_move      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || v_move;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    assign v_rw_clash = r_out_item.ram_write && r_out_item.ram_read;
    assign v_quiet    = !r_out_item.ram_write && !r_out_item.ram_read &&
                        (r_out_item.read_byte == 8'd0);

    pprp_core #(
        .ADDRESS_BITS    (ADDRESS_BITS),
        .PAGE_COUNT_BITS (PAGE_COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (v_move),
        .i_item   (r_in_item),
        .o_result (v_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (v_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (v_move) begin
            r_out_item <= v_result;
        end
    end

    `PPRP_ASSERT_IMP(a_no_read_and_write, r_out_valid, !v_rw_clash)
    `PPRP_ASSERT_IMP(a_locked_quiet, r_out_valid && !r_out_item.port_unlocked, v_quiet)
    `PPRP_ASSERT_NXT(a_move_fills_out, v_move, r_out_valid)

endmodule

`default_nettype wire

/* tb/sv/parallel_port_cart_ram_register_port_tb.sv */
// ----------------------------------------------------------------------------
// parallel_port_cart_ram_register_port_tb
// Drives port strobes and target write events into the register port and
// checks every result against a cycle-free model of the index registers,
// RAM pointer, keys, mode and flags, or against the value a directed row
// gives. A short table of directed strobes comes first, then random strobe
// sequences, with random stalls on both channels and long receiver hold-offs that back up the input.
// ----------------------------------------------------------------------------
module parallel_port_cart_ram_register_port_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pprp_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_COUNT   = 1400;
    localparam int QUIET_TAIL   = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_CYCLES = 8;
    localparam int PAGE_BITS    = 9;
    localparam int PRINT_CAP    = 50;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    // model state
    t_index      cur_index;
    logic [28:0] ram_ptr;
    logic [7:0]  key_hi;
    logic [7:0]  key_lo;
    logic [1:0]  mode;
    logic        wr_flag;
    logic        up_flag;
    logic        off_flag;

    t_out_item pending[$];
    t_row      plan[$];
    int        errors;
    int        sent;
    bit        quiet;
    bit        hold_req;

    parallel_port_cart_ram_register_port dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic bit keys_open();
        return key_hi == KEY_HIGH_VALUE && key_lo == KEY_LOW_VALUE;
    endfunction

    function automatic void advance_ptr();
        ram_ptr[PAGE_BITS-1:0] = ram_ptr[PAGE_BITS-1:0] + 1'b1;
    endfunction

    function automatic t_out_item port_step(input t_in_item it);
        t_out_item r;
        bit        open;
        r = '0;
        open = keys_open();
        case (it.op)
            OP_ADDR_WRITE: cur_index = t_index'(it.port_byte[2:0]);
            OP_DATA_WRITE: begin
                if (cur_index == IDX_KEY_HIGH) begin
                    key_hi = it.port_byte;
                end else if (cur_index == IDX_KEY_LOW) begin
                    key_lo = it.port_byte;
                end else if (open) begin
                    case (cur_index)
                        IDX_ADDR0: ram_ptr[7:0]   = it.port_byte;
                        IDX_ADDR1: ram_ptr[15:8]  = it.port_byte;
                        IDX_ADDR2: ram_ptr[23:16] = it.port_byte;
                        IDX_ADDR3: ram_ptr[28:24] = it.port_byte[4:0];
                        IDX_RAM_DATA: begin
                            r.ram_write      = 1'b1;
                            r.ram_address    = ram_ptr;
                            r.ram_write_byte = it.port_byte;
                            advance_ptr();
                        end
                        IDX_MODE: begin
                            mode = it.port_byte[1:0];
                            if (!mode[0]) wr_flag = 1'b0;
                            if (!mode[1]) begin
                                up_flag  = 1'b0;
                                off_flag = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_DATA_READ: begin
                if (open) begin
                    case (cur_index)
                        IDX_ADDR0: r.read_byte = ram_ptr[7:0];
                        IDX_ADDR1: r.read_byte = ram_ptr[15:8];
                        IDX_ADDR2: r.read_byte = ram_ptr[23:16];
                        IDX_ADDR3: r.read_byte = {it.target_power, wr_flag, up_flag,
                                                  ram_ptr[28:24] & TOP_FIELD_MASK};
                        IDX_RAM_DATA: begin
                            r.ram_read    = 1'b1;
                            r.ram_address = ram_ptr;
                            r.read_byte   = it.ram_return_byte;
                            advance_ptr();
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                if (!it.target_window) begin
                    if (mode[0] && !off_flag) wr_flag = 1'b1;
                end else if (mode[1]) begin
                    up_flag  = 1'b1;
                    off_flag = 1'b1;
                end else if (mode[0]) begin
                    wr_flag = 1'b1;
                end
            end
        endcase
        r.port_unlocked       = keys_open();
        r.cart_at_low_window  = off_flag;
        r.target_ram_writable = mode[0];
        return r;
    endfunction

    function automatic t_in_item make_item(input t_op op, input logic [7:0] pb,
                                           input logic [7:0] rb, input logic win,
                                           input logic pwr);
        t_in_item it;
        it.op              = op;
        it.port_byte       = pb;
        it.ram_return_byte = rb;
        it.target_window   = win;
        it.target_power    = pwr;
        return it;
    endfunction

    function automatic t_in_item rand_item(input t_op op, input logic [7:0] pb);
        return make_item(op, pb, 8'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    function automatic t_out_item outcome(input logic [7:0] rd, input logic unl,
                                          input logic off, input logic wr);
        t_out_item r;
        r = '0;
        r.read_byte           = rd;
        r.port_unlocked       = unl;
        r.cart_at_low_window  = off;
        r.target_ram_writable = wr;
        return r;
    endfunction

    function automatic void add_row(input t_in_item it, input bit typed,
                                    input t_out_item want);
        t_row row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < PRINT_CAP)
            $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending.size() == 0) begin
            report_mismatch("unexpected result", 32'(got.read_byte), 0);
            return;
        end
        want = pending.pop_front();
        if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", 32'(got.read_byte), 32'(want.read_byte));
        if (got.ram_write !== want.ram_write)
            report_mismatch("ram_write", 32'(got.ram_write), 32'(want.ram_write));
        if (got.ram_read !== want.ram_read)
            report_mismatch("ram_read", 32'(got.ram_read), 32'(want.ram_read));
        if (got.ram_address !== want.ram_address)
            report_mismatch("ram_address", 32'(got.ram_address), 32'(want.ram_address));
        if (got.ram_write_byte !== want.ram_write_byte)
            report_mismatch("ram_write_byte", 32'(got.ram_write_byte),
                            32'(want.ram_write_byte));
        if (got.port_unlocked !== want.port_unlocked)
            report_mismatch("port_unlocked", 32'(got.port_unlocked), 32'(want.port_unlocked));
        if (got.cart_at_low_window !== want.cart_at_low_window)
            report_mismatch("cart_at_low_window", 32'(got.cart_at_low_window),
                            32'(want.cart_at_low_window));
        if (got.target_ram_writable !== want.target_ram_writable)
            report_mismatch("target_ram_writable", 32'(got.target_ram_writable),
                            32'(want.target_ram_writable));
    endtask

    // one input transfer; the model runs at the accepting edge
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = port_step(it);
        pending.push_back(typed ? want : pred);
        sent++;
        if (sent == 400 || sent == 1000) hold_req = 1'b1;
        if (sent >= ITEM_COUNT - QUIET_TAIL) quiet = 1'b1;
    endtask

    task automatic send(input t_in_item it);
        send_item(it, 1'b0, '0);
    endtask

    function automatic logic [7:0] index_byte(input t_index idx);
        logic [7:0] pb;
        pb = 8'($urandom);
        pb[2:0] = idx;
        return pb;
    endfunction

    task automatic run_random();
        int         pick;
        int         len;
        logic [7:0] pb;
        while (sent < ITEM_COUNT) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send(rand_item(OP_ADDR_WRITE, index_byte(IDX_KEY_HIGH)));
                send(rand_item(OP_DATA_WRITE, KEY_HIGH_VALUE));
                send(rand_item(OP_ADDR_WRITE, index_byte(IDX_KEY_LOW)));
                send(rand_item(OP_DATA_WRITE, KEY_LOW_VALUE));
            end else if (pick < 12) begin
                send(rand_item(OP_ADDR_WRITE,
                     index_byte($urandom_range(0, 1) ? IDX_KEY_HIGH : IDX_KEY_LOW)));
                send(rand_item(OP_DATA_WRITE, 8'($urandom)));
            end else if (pick < 30) begin
                send(rand_item(OP_ADDR_WRITE, index_byte(t_index'($urandom_range(0, 3)))));
                pb = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
                send(rand_item($urandom_range(0, 3) == 0 ? OP_DATA_READ : OP_DATA_WRITE, pb));
            end else if (pick < 55) begin
                send(rand_item(OP_ADDR_WRITE, index_byte(IDX_RAM_DATA)));
                len = $urandom_range(1, 8);
                repeat (len)
                    send(rand_item($urandom_range(0, 1) ? OP_DATA_READ : OP_DATA_WRITE,
                                   8'($urandom)));
            end else if (pick < 62) begin
                send(rand_item(OP_ADDR_WRITE, index_byte(IDX_MODE)));
                send(rand_item(OP_DATA_WRITE, 8'($urandom)));
            end else if (pick < 70) begin
                send(rand_item(OP_ADDR_WRITE, index_byte(IDX_ADDR3)));
                send(rand_item(OP_DATA_READ, 8'($urandom)));
            end else if (pick < 85) begin
                send(rand_item(OP_TARGET_WRITE, 8'($urandom)));
            end else begin
                send(rand_item(t_op'($urandom_range(0, 3)), 8'($urandom)));
            end
        end
    endtask

    // receiver: random stalls plus the long hold-offs
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) check_result(o_out_data);
        end
    end

    // watchdog: cycles without any transfer
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        errors      = 0;
        sent        = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        cur_index   = IDX_ADDR0;
        ram_ptr     = '0;
        key_hi      = '0;
        key_lo      = '0;
        mode        = '0;
        wr_flag     = 1'b0;
        up_flag     = 1'b0;
        off_flag    = 1'b0;

        // locked after reset, then unlock and walk the pointer to its top
        add_row(make_item(OP_DATA_READ, 8'h00, 8'hff, 1'b1, 1'b1), 1, '0);
        add_row(make_item(OP_DATA_WRITE, 8'hff, 8'h00, 1'b0, 1'b0), 1, '0);
        add_row(make_item(OP_ADDR_WRITE, 8'hfe, 8'h00, 1'b0, 1'b0), 1, '0);
        add_row(make_item(OP_DATA_WRITE, KEY_HIGH_VALUE, 8'h00, 1'b0, 1'b0), 1, '0);
        add_row(make_item(OP_ADDR_WRITE, 8'h07, 8'h00, 1'b0, 1'b0), 1, '0);
        add_row(make_item(OP_DATA_WRITE, KEY_LOW_VALUE, 8'h00, 1'b0, 1'b0), 1,
                outcome(8'h00, 1'b1, 1'b0, 1'b0));
        for (int k = 0; k < 4; k++) begin
            add_row(make_item(OP_ADDR_WRITE, 8'(k), 8'h00, 1'b0, 1'b0), 0, '0);
            add_row(make_item(OP_DATA_WRITE, 8'hff, 8'h00, 1'b0, 1'b0), 0, '0);
        end
        add_row(make_item(OP_DATA_READ, 8'h00, 8'h00, 1'b0, 1'b1), 1,
                outcome(8'h9f, 1'b1, 1'b0, 1'b0));
        // RAM transfers at the page top wrap inside the page
        add_row(make_item(OP_ADDR_WRITE, 8'h04, 8'h00, 1'b0, 1'b0), 0, '0);
        add_row(make_item(OP_DATA_WRITE, 8'h00, 8'hff, 1'b0, 1'b0), 0, '0);
        add_row(make_item(OP_DATA_READ, 8'h00, 8'hff, 1'b0, 1'b0), 0, '0);
        // mode, target events in both windows, write-only read
        add_row(make_item(OP_ADDR_WRITE, 8'h05, 8'h00, 1'b0, 1'b0), 0, '0);
        add_row(make_item(OP_DATA_WRITE, 8'hff, 8'h00, 1'b0, 1'b0), 0, '0);
        add_row(make_item(OP_TARGET_WRITE, 8'h00, 8'h00, 1'b0, 1'b0), 0, '0);
        add_row(make_item(OP_TARGET_WRITE, 8'hff, 8'hff, 1'b1, 1'b1), 0, '0);
        add_row(make_item(OP_DATA_READ, 8'h00, 8'hff, 1'b0, 1'b0), 1,
                outcome(8'h00, 1'b1, 1'b1, 1'b1));
        add_row(make_item(OP_ADDR_WRITE, 8'hf3, 8'h00, 1'b0, 1'b0), 0, '0);
        add_row(make_item(OP_DATA_READ, 8'h00, 8'h00, 1'b0, 1'b0), 0, '0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send_item(plan[k].item, plan[k].typed, plan[k].want);
        run_random();
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
